// ----- design/mrm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared constants and types for the MIDI event route matcher.
// ----------------------------------------------------------------------------
package mrm_pkg;

   localparam int ROUTE_SLOTS = 8;
   localparam int NUM_ROUTES  = 8;
   localparam int ROUTE_IDX_W = 3;
   localparam int ROUTE_W     = 31;
   localparam int SLOT_W      = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
   localparam logic [7:0] CHAN_MASK     = 8'h0F;
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_POLY_AT  = 4'hA;
   localparam logic [6:0] NOTE_MAX      = 7'd127;

   typedef struct packed {
      logic [2:0] device;
      logic [1:0] length;
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
      logic       is_empty;
      logic       is_system;
      logic       is_note_kind;
      logic [4:0] chan_code;
   } mrm_item_type;

endpackage

// ----- design/mrm_front.sv -----
// ----------------------------------------------------------------------------
// mrm_front
// Input stage: takes one event, masks bytes past its length and classifies it.
// ----------------------------------------------------------------------------
module mrm_front
   import mrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_source_device,
   input  logic [1:0]   req_event_length,
   input  logic [7:0]   req_status_byte,
   input  logic [7:0]   req_first_data,
   input  logic [7:0]   req_second_data,
   output logic         push_valid,
   input  logic         push_ready,
   output mrm_item_type push_item
);

   logic         valid_ff;
   logic         valid_in;
   mrm_item_type item_ff;
   mrm_item_type item_in;
   logic         take;
   logic [3:0]   kind;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;
   assign kind       = req_status_byte[7:4];

   always_comb begin
      item_in.device   = req_source_device;
      item_in.length   = req_event_length;
      item_in.is_empty = (req_event_length == 2'd0);
      item_in.status   = item_in.is_empty ? 8'd0 : req_status_byte;
      item_in.first    = (req_event_length < 2'd2) ? 8'd0 : req_first_data;
      item_in.second   = (req_event_length < 2'd3) ? 8'd0 : req_second_data;
      item_in.is_system = (item_in.status >= STATUS_SYSTEM);
      item_in.is_note_kind = ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON) ||
                              (kind == KIND_POLY_AT)) && (req_event_length >= 2'd2);
      item_in.chan_code = {1'b0, req_status_byte[3:0] & CHAN_MASK[3:0]} + 5'd1;
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (valid_ff && push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- design/mrm_queue.sv -----
// ----------------------------------------------------------------------------
// mrm_queue
// Short queue of classified events between the front and back stages.
// ----------------------------------------------------------------------------
module mrm_queue
   import mrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  mrm_item_type wr_item,
   output logic         rd_valid,
   input  logic         rd_pop,
   output mrm_item_type rd_item
);

   mrm_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              do_wr;
   logic              do_rd;

   assign wr_ready = (count_ff < (QPTR_W+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on write");
`endif

endmodule

// ----- design/mrm_back.sv -----
// ----------------------------------------------------------------------------
// mrm_back
// Route table and scanner: one slot per cycle unless rsp_ stalls; emits matches
// ----------------------------------------------------------------------------
module mrm_back
   import mrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [ROUTE_IDX_W-1:0] csr_index,
   input  logic [ROUTE_W-1:0]     csr_data,
   input  logic                   q_valid,
   input  mrm_item_type           q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_target_node,
   output logic [2:0]             rsp_route_slot,
   output logic [1:0]             rsp_out_length,
   output logic [7:0]             rsp_out_status,
   output logic [7:0]             rsp_out_first,
   output logic [7:0]             rsp_out_second,
   output logic                   rsp_last
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ROUTE_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_SCAN  = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   logic [ROUTE_W-1:0] route_ff [NUM_ROUTES];
   state_type          state_ff;
   state_type          state_in;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic               pend_valid_ff;
   logic               pend_valid_in;
   logic [7:0]         pend_node_ff;
   logic [SLOT_W-1:0]  pend_slot_ff;
   logic               pend_load;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_node_ff;
   logic [2:0]         rsp_slot_ff;
   logic [1:0]         rsp_length_ff;
   logic [7:0]         rsp_status_ff;
   logic [7:0]         rsp_first_ff;
   logic [7:0]         rsp_second_ff;
   logic               rsp_last_ff;
   logic               out_load;
   logic               out_last;
   logic               out_free;

   logic [ROUTE_W-1:0] route;
   logic [7:0]         r_node;
   logic [4:0]         r_chan;
   logic [6:0]         r_low;
   logic [6:0]         r_high;
   logic               chan_ok;
   logic               range_ok;
   logic               slot_match;

   assign route  = route_ff[ROUTE_IDX_W'(slot_ff)];
   assign r_node = route[11:4];
   assign r_chan = route[16:12];
   assign r_low  = route[23:17];
   assign r_high = route[30:24];

   always_comb begin
      chan_ok  = (r_chan == 5'd0) || (r_chan == q_item.chan_code);
      range_ok = ((r_low == 7'd0) && (r_high == NOTE_MAX)) || !q_item.is_note_kind ||
                 ((q_item.first >= {1'b0, r_low}) && (q_item.first <= {1'b0, r_high}));
      slot_match = route[0] && (route[3:1] == q_item.device) && !q_item.is_empty &&
                   (q_item.is_system || (chan_ok && range_ok));
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_load     = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      q_pop         = 1'b0;
      unique case (state_ff)
         ST_SCAN: begin
            if (q_valid && !(slot_match && pend_valid_ff && !out_free)) begin
               if (slot_match) begin
                  out_load      = pend_valid_ff;
                  pend_load     = 1'b1;
                  pend_valid_in = 1'b1;
               end
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  state_in = ST_FLUSH;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               q_pop    = 1'b1;
               state_in = ST_SCAN;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               q_pop         = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SCAN;
         slot_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_ROUTES; i++) begin
            route_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            route_ff[csr_index] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_node_ff <= r_node;
         pend_slot_ff <= slot_ff;
      end
      if (out_load) begin
         rsp_node_ff   <= pend_node_ff;
         rsp_slot_ff   <= 3'(pend_slot_ff);
         rsp_length_ff <= q_item.length;
         rsp_status_ff <= q_item.status;
         rsp_first_ff  <= q_item.first;
         rsp_second_ff <= q_item.second;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_node = rsp_node_ff;
   assign rsp_route_slot  = rsp_slot_ff;
   assign rsp_out_length  = rsp_length_ff;
   assign rsp_out_status  = rsp_status_ff;
   assign rsp_out_first   = rsp_first_ff;
   assign rsp_out_second  = rsp_second_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_flush_has_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> q_valid)
      else $error("flush without a queued event");
   a_pend_has_item: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> q_valid)
      else $error("pending match without a queued event");
   a_last_clears_pend: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last) |=> !pend_valid_ff)
      else $error("pending match left after last transfer");
   a_slot_idle_in_flush: assert property (@(posedge clock) disable iff (reset)
      (slot_ff != '0) |-> (state_ff == ST_SCAN))
      else $error("slot counter moved outside scan");
`endif

endmodule

// ----- design/midi_event_route_matcher_core.sv -----
// ----------------------------------------------------------------------------
// midi_event_route_matcher_core
// Matches MIDI events against eight configured route slots, one transfer
// per matching slot in slot order, last marked on the final one.
//
//   channel  direction  transfer content
//   req_     in         source device, length, status, two data bytes
//   rsp_     out        target node, slot, event passed through, last
//   csr_     in         route slot index and packed route word
//
// The back stage checks one slot per cycle while no match waits on rsp_ready, then
// flushes the held match, marked last, before it pops the event from the queue.
// The front register and a two-entry queue take up to two more events meanwhile.
// Reset clears the route table, the queue and all valid flags.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module midi_event_route_matcher_core
   import mrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_source_device,
   input  logic [1:0]             req_event_length,
   input  logic [7:0]             req_status_byte,
   input  logic [7:0]             req_first_data,
   input  logic [7:0]             req_second_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_target_node,
   output logic [2:0]             rsp_route_slot,
   output logic [1:0]             rsp_out_length,
   output logic [7:0]             rsp_out_status,
   output logic [7:0]             rsp_out_first,
   output logic [7:0]             rsp_out_second,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ROUTE_IDX_W-1:0] csr_index,
   input  logic [ROUTE_W-1:0]     csr_data
);

   logic         push_valid;
   logic         push_ready;
   mrm_item_type push_item;
   logic         q_valid;
   logic         q_pop;
   mrm_item_type q_item;

   assign csr_ready = 1'b1;

   mrm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_device (req_source_device),
      .req_event_length  (req_event_length),
      .req_status_byte   (req_status_byte),
      .req_first_data    (req_first_data),
      .req_second_data   (req_second_data),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   mrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_item  (push_item),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_item  (q_item)
   );

   mrm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_target_node (rsp_target_node),
      .rsp_route_slot  (rsp_route_slot),
      .rsp_out_length  (rsp_out_length),
      .rsp_out_status  (rsp_out_status),
      .rsp_out_first   (rsp_out_first),
      .rsp_out_second  (rsp_out_second),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- bench/route_match_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// route_match_tb_pkg
// Route table mirror, match prediction and transfer checking for the MIDI
// event route matcher bench. Each accepted event is expanded into the
// transfers it should cause; each rsp_ transfer is checked against the
// oldest one still outstanding.
// ----------------------------------------------------------------------------
package route_match_tb_pkg;

   import mrm_pkg::*;

   typedef struct packed {
      logic [7:0] node;
      logic [2:0] slot;
      logic [1:0] length;
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
      logic       last;
   } route_delivery_type;

   class route_match_tracker;

      logic [ROUTE_W-1:0] route_table [NUM_ROUTES];
      route_delivery_type pending_deliveries [$];
      int                 mismatch_count;

      function new();
         foreach (route_table[i]) route_table[i] = '0;
         mismatch_count = 0;
      endfunction

      function void set_route(int idx, logic [ROUTE_W-1:0] word);
         if (idx < NUM_ROUTES) route_table[idx] = word;
      endfunction

      function int outstanding();
         return pending_deliveries.size();
      endfunction

      function bit slot_accepts(logic [ROUTE_W-1:0] word, logic [2:0] device,
                                logic [1:0] length, logic [7:0] status,
                                logic [7:0] note);
         logic [4:0] chan_filter;
         logic [6:0] low_note;
         logic [6:0] high_note;
         logic [3:0] kind;
         chan_filter = word[16:12];
         low_note    = word[23:17];
         high_note   = word[30:24];
         kind        = status[7:4];
         if (!word[0] || word[3:1] != device || length == 2'd0) return 1'b0;
         if (status >= STATUS_SYSTEM) return 1'b1;
         if (chan_filter != 5'd0 && ((status & CHAN_MASK) + 1) != chan_filter)
            return 1'b0;
         if (!(low_note == 7'd0 && high_note == NOTE_MAX) && length >= 2'd2 &&
             (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON || kind == KIND_POLY_AT) &&
             (note < low_note || note > high_note))
            return 1'b0;
         return 1'b1;
      endfunction

      function void note_event(logic [2:0] device, logic [1:0] length,
                               logic [7:0] status, logic [7:0] first,
                               logic [7:0] second);
         route_delivery_type d;
         int                 base;
         base = pending_deliveries.size();
         for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (slot_accepts(route_table[s], device, length, status, first)) begin
               d.node   = route_table[s][11:4];
               d.slot   = 3'(s);
               d.length = length;
               d.status = (length >= 2'd1) ? status : 8'd0;
               d.first  = (length >= 2'd2) ? first : 8'd0;
               d.second = (length == 2'd3) ? second : 8'd0;
               d.last   = 1'b0;
               pending_deliveries = {pending_deliveries, d};
            end
         end
         if (pending_deliveries.size() > base)
            pending_deliveries[pending_deliveries.size() - 1].last = 1'b1;
      endfunction

      task report(string what);
         mismatch_count++;
         if (mismatch_count <= 40) $display("%0t: %s", $time, what);
      endtask

      task compare_field(string name, int got, int want, int slot);
         if (got != want)
            report($sformatf("slot %0d %s: got 0x%0h, expected 0x%0h",
                             slot, name, got, want));
      endtask

      task check_delivery(route_delivery_type got);
         route_delivery_type want;
         if (pending_deliveries.size() == 0) begin
            report($sformatf("unexpected transfer, slot %0d node 0x%0h",
                             got.slot, got.node));
            return;
         end
         want = pending_deliveries.pop_front();
         compare_field("route_slot", got.slot, want.slot, want.slot);
         compare_field("target_node", got.node, want.node, want.slot);
         compare_field("out_length", got.length, want.length, want.slot);
         compare_field("out_status", got.status, want.status, want.slot);
         compare_field("out_first", got.first, want.first, want.slot);
         compare_field("out_second", got.second, want.second, want.slot);
         compare_field("last", got.last, want.last, want.slot);
      endtask

      task check_drained();
         if (pending_deliveries.size() != 0)
            report($sformatf("%0d expected transfers never arrived",
                             pending_deliveries.size()));
      endtask

   endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for midi_event_route_matcher_core. Programs the route table over
// csr_, sends directed corner events and then random, mostly routable
// events over req_, and checks every rsp_ transfer against the predicted
// matches in slot order, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mrm_pkg::*;
   import route_match_tb_pkg::*;

   localparam logic [3:0] KIND_CONTROL = 4'hB;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_source_device = '0;
   logic [1:0]             req_event_length = '0;
   logic [7:0]             req_status_byte = '0;
   logic [7:0]             req_first_data = '0;
   logic [7:0]             req_second_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_target_node;
   logic [2:0]             rsp_route_slot;
   logic [1:0]             rsp_out_length;
   logic [7:0]             rsp_out_status;
   logic [7:0]             rsp_out_first;
   logic [7:0]             rsp_out_second;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ROUTE_IDX_W-1:0] csr_index = '0;
   logic [ROUTE_W-1:0]     csr_data = '0;

   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   int                 idle_plan [4] = '{0, 79, 0, 25};
   int                 stall_plan [4] = '{0, 0, 79, 25};
   logic [ROUTE_W-1:0] table_plan [NUM_ROUTES];
   route_match_tracker tracker;

   midi_event_route_matcher_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_device (req_source_device),
      .req_event_length  (req_event_length),
      .req_status_byte   (req_status_byte),
      .req_first_data    (req_first_data),
      .req_second_data   (req_second_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target_node   (rsp_target_node),
      .rsp_route_slot    (rsp_route_slot),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_status    (rsp_out_status),
      .rsp_out_first     (rsp_out_first),
      .rsp_out_second    (rsp_out_second),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_delivery('{node: rsp_target_node, slot: rsp_route_slot,
                                  length: rsp_out_length, status: rsp_out_status,
                                  first: rsp_out_first, second: rsp_out_second,
                                  last: rsp_last});
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic logic [ROUTE_W-1:0] pack_route(bit valid, int device, int node,
                                                     int chan_filter, int low_note,
                                                     int high_note);
      return {7'(high_note), 7'(low_note), 5'(chan_filter), 8'(node), 3'(device), valid};
   endfunction

   function automatic logic [ROUTE_W-1:0] random_route();
      int pick;
      int chan_filter;
      int low_note;
      int high_note;
      pick = $urandom_range(99);
      if (pick < 50) chan_filter = 0;
      else if (pick < 80) chan_filter = $urandom_range(4, 1);
      else if (pick < 90) chan_filter = $urandom_range(16, 5);
      else chan_filter = $urandom_range(31, 17);
      pick = $urandom_range(99);
      if (pick < 30) begin
         low_note  = 0;
         high_note = 127;
      end else if (pick < 40) begin
         low_note  = $urandom_range(127, 1);
         high_note = $urandom_range(low_note - 1);
      end else begin
         low_note  = $urandom_range(100);
         high_note = $urandom_range(127, low_note);
      end
      return pack_route($urandom_range(9) != 0,
                        ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3),
                        $urandom_range(255), chan_filter, low_note, high_note);
   endfunction

   task automatic load_routes();
      for (int i = 0; i < NUM_ROUTES; i++) begin
         csr_valid <= 1'b1;
         csr_index <= ROUTE_IDX_W'(i);
         csr_data  <= table_plan[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.set_route(i, table_plan[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_event(int device, int length, int status, int first_byte,
                             int second_byte);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid         <= 1'b1;
      req_source_device <= 3'(device);
      req_event_length  <= 2'(length);
      req_status_byte   <= 8'(status);
      req_first_data    <= 8'(first_byte);
      req_second_data   <= 8'(second_byte);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_event(3'(device), 2'(length), 8'(status), 8'(first_byte),
                         8'(second_byte));
   endtask

   task automatic send_random_event();
      int pick;
      int length;
      int status;
      int kind;
      int chan;
      pick = $urandom_range(99);
      if (pick < 70) length = 3;
      else if (pick < 80) length = 2;
      else if (pick < 90) length = 1;
      else length = 0;
      pick = $urandom_range(99);
      if (pick < 15) begin
         status = $urandom_range(255, 240);
      end else if (pick < 20) begin
         status = $urandom_range(255);
      end else begin
         kind   = (pick < 65) ? KIND_NOTE_OFF + $urandom_range(2) : $urandom_range(14, 11);
         chan   = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15);
         status = kind * 16 + chan;
      end
      send_event(($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(7),
                 length, status,
                 ($urandom_range(99) < 85) ? $urandom_range(127) : $urandom_range(255, 128),
                 $urandom_range(255));
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (64) @(posedge clock);
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      send_event(0, 3, {KIND_NOTE_ON, 4'h0}, 60, 100);
      send_event(3, 1, 8'hF8, 0, 0);
      settle();

      table_plan[0] = pack_route(1, 0, 8'h10, 0, 0, 127);
      table_plan[1] = pack_route(1, 0, 8'h11, 1, 60, 72);
      table_plan[2] = pack_route(1, 0, 8'h12, 17, 0, 127);
      table_plan[3] = pack_route(1, 0, 8'h13, 0, 80, 40);
      table_plan[4] = pack_route(0, 0, 8'h14, 0, 0, 127);
      table_plan[5] = pack_route(1, 1, 8'h15, 16, 0, 126);
      table_plan[6] = pack_route(1, 0, 8'hA5, 0, 0, 0);
      table_plan[7] = pack_route(1, 7, 8'h00, 0, 127, 127);
      load_routes();
      send_event(0, 0, {KIND_NOTE_ON, 4'h0}, 64, 100);
      send_event(0, 3, {KIND_NOTE_ON, 4'h0}, 64, 100);
      send_event(0, 3, {KIND_NOTE_ON, 4'h0}, 30, 1);
      send_event(0, 3, {KIND_NOTE_ON, 4'h0}, 200, 2);
      send_event(0, 3, {KIND_NOTE_ON, 4'h0}, 0, 3);
      send_event(0, 1, {KIND_NOTE_OFF, 4'h0}, 99, 99);
      send_event(0, 2, {KIND_POLY_AT, 4'h0}, 65, 77);
      send_event(0, 3, {KIND_CONTROL, 4'h0}, 99, 5);
      send_event(0, 1, STATUS_SYSTEM, 12, 34);
      send_event(0, 3, 8'hFF, 255, 255);
      send_event(1, 3, {KIND_NOTE_ON, 4'hF}, 127, 9);
      send_event(1, 3, {KIND_NOTE_ON, 4'hF}, 126, 9);
      send_event(1, 3, {KIND_NOTE_ON, 4'hE}, 10, 9);
      send_event(7, 3, {KIND_NOTE_OFF, 4'h0}, 127, 0);
      send_event(7, 3, {KIND_NOTE_OFF, 4'h0}, 126, 0);
      send_event(2, 3, {KIND_NOTE_ON, 4'h0}, 64, 64);
      send_event(0, 1, 8'h05, 0, 0);
      settle();

      foreach (table_plan[i]) table_plan[i] = '1;
      load_routes();
      send_event(7, 1, 8'hF7, 200, 201);
      send_event(7, 3, {KIND_NOTE_ON, 4'h3}, 127, 127);
      send_event(7, 0, STATUS_SYSTEM, 1, 2);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_plan[phase];
         receiver_stall_pct = stall_plan[phase];
         foreach (table_plan[i]) table_plan[i] = random_route();
         load_routes();
         repeat (80) send_random_event();
         settle();
      end

      tracker.check_drained();
      if (tracker.mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
